@@ src/mm2_pkg.sv @@
// Package: shared types and constants for the modulation matrix with exp2 factor.
`timescale 1ns / 1ps
package mm2_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PITCH_BEND = 3'd0;
  localparam logic [2:0] CFG_MOD_WHEEL  = 3'd1;
  localparam logic [2:0] CFG_BREATH     = 3'd2;
  localparam logic [2:0] CFG_ROUTES     = 3'd3;
  localparam logic [2:0] CFG_KEY_CENTER = 3'd4;

  // Item kinds carried on in_tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // Source codes
  localparam logic [3:0] SRC_CONST  = 4'd0;
  localparam logic [3:0] SRC_KEY    = 4'd1;
  localparam logic [3:0] SRC_BEND   = 4'd2;
  localparam logic [3:0] SRC_LFO1   = 4'd3;
  localparam logic [3:0] SRC_LFO2   = 4'd4;
  localparam logic [3:0] SRC_EG     = 4'd5;
  localparam logic [3:0] SRC_VELO   = 4'd6;
  localparam logic [3:0] SRC_EGVELO = 4'd7;
  localparam logic [3:0] SRC_WHEEL  = 4'd8;
  localparam logic [3:0] SRC_BREATH = 4'd9;

  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 56;

  // Rounding and division by the common denominator 3 * 2^23
  localparam logic signed [ACC_W-1:0] HALF_DENOM = 56'sd12582912;
  localparam logic signed [33:0] DIV_LIMIT = 34'sd196608;
  localparam logic [MUL_W-1:0] RECIP_3 = 25'd349526;  // ceil(2^20 / 3)

  // exp2 polynomial coefficients, Q0.16
  localparam logic [MUL_W-1:0] POLY_C    = 25'd22267;
  localparam logic [MUL_W-1:0] POLY_1MC  = 25'd43269;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_EGW, ST_ROUTE, ST_RND, ST_DIV, ST_DIVR,
    ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]         source;
    logic [4:0]         destination;
    logic signed [16:0] amount;
  } route_t;

  // Input payload, last declared field in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic [14:0]        eg_value;
    logic signed [15:0] lfo2_value;
    logic signed [15:0] lfo1_value;
    logic [6:0]         velocity;
    logic [6:0]         note;
    logic [4:0]         query_destination;
    logic signed [16:0] route_amount;
    logic [4:0]         route_destination;
    logic [3:0]         route_source;
    logic [4:0]         route_index;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic               saturated;
    logic [31:0]        mod_factor;
    logic signed [16:0] mod_sum;
  } out_item_t;

endpackage

@@ src/mm2_route_ram.sv @@
// Route table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module mm2_route_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  mm2_pkg::route_t    wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output mm2_pkg::route_t    rd_data
);

  mm2_pkg::route_t mem [DEPTH];
  mm2_pkg::route_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/mm2_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module mm2_mul (
  input  logic                                 clk,
  input  logic signed [mm2_pkg::MUL_W-1:0]     op_a,
  input  logic signed [mm2_pkg::MUL_W-1:0]     op_b,
  output logic signed [mm2_pkg::PROD_W-1:0]    prod
);

  logic signed [mm2_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

@@ src/modulation_matrix_exp2.sv @@
// Top level: modulation matrix sequencer, accumulator and exp2 factor.
//
// Input stream (in_*): one transaction is a write item (in_tuser = 0, stores
// one route) or an evaluate item (in_tuser = 1, sums the routes of one
// destination for a voice). Every input transaction yields exactly one result
// transaction on out_*: summed modulation, its 2^x factor and a clamp flag.
// Configuration (cfg_*) writes controller values and the route count; it is
// always ready. Route count and key centre are taken when an item is
// accepted; bend, wheel and breath are read while the routes are summed.
// A write item goes straight to its result; an evaluate item walks the N
// routes in use (capped at TABLE_DEPTH): the shared multiplier takes one
// route per cycle through the pipelined table read, then does the divide by
// three and three polynomial products.
// One item is in the block at a time: in_tready is low from acceptance until
// the result transaction completes and rises the cycle after, so the block
// takes no new item until the result of the last one has been taken.
// Reset clears the controller registers (key centre to 52) and the sequencer;
// the route table is not cleared and must be written before use. While the
// receiver holds out_tready low the result stays on out_tdata unchanged.
`timescale 1ns / 1ps
module modulation_matrix_exp2 #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // cfg channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: route_index[4:0] route_source[8:5] route_destination[13:9]
  // route_amount[30:14] query_destination[35:31] note[42:36] velocity[49:43]
  // lfo1_value[65:50] lfo2_value[81:66] eg_value[96:82], zero pad above
  input  logic [103:0] in_tdata,
  // tuser: func[0]
  input  logic         in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: mod_sum[16:0] mod_factor[48:17] saturated[49], zero pad above
  output logic [55:0]  out_tdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = mm2_pkg::MUL_W;
  localparam int AC = mm2_pkg::ACC_W;

  mm2_pkg::state_t state_r, state_nxt;
  mm2_pkg::in_item_t item;
  mm2_pkg::route_t rd_route, wr_route;

  // Configuration registers
  logic signed [15:0] bend_r;
  logic [6:0] wheel_r, breath_r, kc_r;
  logic [5:0] riu_r;

  // Item registers
  logic [4:0] qd_r;
  logic signed [7:0] key_r;
  logic [6:0] vel_r;
  logic signed [15:0] l1_r, l2_r;
  logic [14:0] eg_r;
  logic [21:0] egvel_r;

  // Walk and pipeline
  logic [CW-1:0] cnt_r, lim_r;
  logic v1_r, v2_r;
  logic [3:0] src2_r;
  logic signed [AC-1:0] acc_r;
  logic issue;

  // Finishing
  logic signed [33:0] v_r;
  logic hi_r, lo_r, sat_r;
  logic signed [16:0] sum_r;
  logic [23:0] ff_r;
  logic [27:0] t1_r;
  logic [38:0] t2_r;
  logic [31:0] factor_r;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [mm2_pkg::PROD_W-1:0] prod;

  logic wr_en, in_range;
  logic [AW+4:0] wr_ext;

  assign item = mm2_pkg::in_item_t'(in_tdata);
  assign cfg_ready = 1'b1;

  // Table write decode
  assign in_range = (32'(item.route_index) < TABLE_DEPTH);
  assign wr_ext   = (AW + 5)'(item.route_index);
  assign wr_en    = in_tvalid && in_tready && (in_tuser == mm2_pkg::FUNC_WRITE) && in_range;
  assign wr_route = '{source: item.route_source, destination: item.route_destination,
                      amount: item.route_amount};
  assign issue    = (state_r == mm2_pkg::ST_ROUTE) && (cnt_r != lim_r);

  mm2_route_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ext[AW-1:0]),
    .wr_data (wr_route),
    .rd_en   (issue),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_route)
  );

  mm2_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Source value of the route read last cycle
  logic signed [MW-1:0] src_x;
  logic src_ok;
  always_comb begin
    src_ok = 1'b1;
    case (rd_route.source)
      mm2_pkg::SRC_CONST:  src_x = MW'(1);
      mm2_pkg::SRC_KEY:    src_x = MW'(key_r);
      mm2_pkg::SRC_BEND:   src_x = MW'(bend_r);
      mm2_pkg::SRC_LFO1:   src_x = MW'(l1_r);
      mm2_pkg::SRC_LFO2:   src_x = MW'(l2_r);
      mm2_pkg::SRC_EG:     src_x = MW'({1'b0, eg_r});
      mm2_pkg::SRC_VELO:   src_x = MW'({1'b0, vel_r});
      mm2_pkg::SRC_EGVELO: src_x = MW'({1'b0, egvel_r});
      mm2_pkg::SRC_WHEEL:  src_x = MW'({1'b0, wheel_r});
      mm2_pkg::SRC_BREATH: src_x = MW'({1'b0, breath_r});
      default: begin
        src_x  = '0;
        src_ok = 1'b0;
      end
    endcase
  end

  // Scale product to the common denominator
  logic signed [AC-1:0] p_ext, p12, term;
  assign p_ext = AC'(prod);
  assign p12   = (p_ext <<< 3) + (p_ext <<< 2);
  always_comb begin
    case (src2_r)
      mm2_pkg::SRC_CONST:  term = p12 <<< 21;
      mm2_pkg::SRC_KEY:    term = p_ext <<< 21;
      mm2_pkg::SRC_BEND,
      mm2_pkg::SRC_LFO1,
      mm2_pkg::SRC_LFO2,
      mm2_pkg::SRC_EG:     term = p12 <<< 7;
      mm2_pkg::SRC_VELO,
      mm2_pkg::SRC_WHEEL,
      mm2_pkg::SRC_BREATH: term = p12 <<< 14;
      mm2_pkg::SRC_EGVELO: term = p12;
      default:             term = '0;
    endcase
  end

  // Clamp and divide-by-three operand
  logic hi_c, lo_c;
  logic signed [33:0] u_full;
  assign hi_c   = (v_r >= mm2_pkg::DIV_LIMIT);
  assign lo_c   = (v_r < -mm2_pkg::DIV_LIMIT);
  assign u_full = v_r + mm2_pkg::DIV_LIMIT;

  // Quotient back to a signed sum: subtract 2^16 by flipping the top bit
  logic [16:0] q;
  assign q = prod[36:20] ^ 17'h10000;

  // Final polynomial scale and round
  logic [41:0] poly, rnd, r_val;
  logic signed [4:0] ip;
  logic [5:0] sh;
  assign poly  = (42'd1 << 40) + (42'(t1_r) << 12) + 42'(t2_r);
  assign ip    = sum_r[16:12];
  assign sh    = 6'd24 - 6'(ip);
  assign rnd   = 42'd1 << (sh - 6'd1);
  assign r_val = (poly + rnd) >> sh;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mm2_pkg::ST_IDLE:
        if (in_tvalid) begin
          state_nxt = (in_tuser == mm2_pkg::FUNC_EVAL) ? mm2_pkg::ST_SETUP : mm2_pkg::ST_OUT;
        end
      mm2_pkg::ST_SETUP: state_nxt = mm2_pkg::ST_EGW;
      mm2_pkg::ST_EGW:   state_nxt = mm2_pkg::ST_ROUTE;
      mm2_pkg::ST_ROUTE:
        if (!issue && !v1_r && !v2_r) begin
          state_nxt = mm2_pkg::ST_RND;
        end
      mm2_pkg::ST_RND:   state_nxt = mm2_pkg::ST_DIV;
      mm2_pkg::ST_DIV:   state_nxt = mm2_pkg::ST_DIVR;
      mm2_pkg::ST_DIVR:  state_nxt = mm2_pkg::ST_E1;
      mm2_pkg::ST_E1:    state_nxt = mm2_pkg::ST_E2;
      mm2_pkg::ST_E2:    state_nxt = mm2_pkg::ST_E3;
      mm2_pkg::ST_E3:    state_nxt = mm2_pkg::ST_E4;
      mm2_pkg::ST_E4:    state_nxt = mm2_pkg::ST_E5;
      mm2_pkg::ST_E5:    state_nxt = mm2_pkg::ST_OUT;
      mm2_pkg::ST_OUT:
        if (out_tready) begin
          state_nxt = mm2_pkg::ST_IDLE;
        end
      default:           state_nxt = mm2_pkg::ST_IDLE;
    endcase
  end

  // Outputs and multiplier operand selection
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_r)
      mm2_pkg::ST_IDLE:  in_tready = 1'b1;
      mm2_pkg::ST_SETUP: begin
        mul_a = MW'({1'b0, eg_r});
        mul_b = MW'({1'b0, vel_r});
      end
      mm2_pkg::ST_ROUTE: begin
        mul_a = MW'(rd_route.amount);
        mul_b = src_x;
      end
      mm2_pkg::ST_DIV: begin
        mul_a = MW'({1'b0, u_full[18:0]});
        mul_b = mm2_pkg::RECIP_3;
      end
      mm2_pkg::ST_E1: begin
        mul_a = MW'({1'b0, sum_r[11:0]});
        mul_b = MW'({1'b0, sum_r[11:0]});
      end
      mm2_pkg::ST_E2: begin
        mul_a = mm2_pkg::POLY_1MC;
        mul_b = MW'({1'b0, sum_r[11:0]});
      end
      mm2_pkg::ST_E3: begin
        mul_a = mm2_pkg::POLY_C;
        mul_b = MW'({1'b0, ff_r});
      end
      mm2_pkg::ST_OUT:   out_tvalid = 1'b1;
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mm2_pkg::ST_IDLE;
      bend_r   <= '0;
      wheel_r  <= '0;
      breath_r <= '0;
      riu_r    <= '0;
      kc_r     <= 7'd52;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          mm2_pkg::CFG_PITCH_BEND: bend_r   <= cfg_data;
          mm2_pkg::CFG_MOD_WHEEL:  wheel_r  <= cfg_data[6:0];
          mm2_pkg::CFG_BREATH:     breath_r <= cfg_data[6:0];
          mm2_pkg::CFG_ROUTES:     riu_r    <= cfg_data[5:0];
          mm2_pkg::CFG_KEY_CENTER: kc_r     <= cfg_data[6:0];
          default: begin
            riu_r <= riu_r;
          end
        endcase
      end
      v1_r <= issue;
      v2_r <= v1_r && (rd_route.destination == qd_r) && src_ok;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    src2_r <= rd_route.source;
    case (state_r)
      mm2_pkg::ST_IDLE: begin
        qd_r  <= item.query_destination;
        key_r <= $signed({1'b0, item.note}) - $signed({1'b0, kc_r});
        vel_r <= item.velocity;
        l1_r  <= item.lfo1_value;
        l2_r  <= item.lfo2_value;
        eg_r  <= item.eg_value;
        lim_r <= (32'(riu_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(riu_r);
        sum_r    <= '0;
        factor_r <= 32'h0001_0000;
        sat_r    <= 1'b0;
      end
      mm2_pkg::ST_SETUP: begin
        cnt_r <= '0;
        acc_r <= '0;
      end
      mm2_pkg::ST_EGW: egvel_r <= prod[21:0];
      mm2_pkg::ST_ROUTE: begin
        if (issue) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (v2_r) begin
          acc_r <= acc_r + term;
        end
      end
      mm2_pkg::ST_RND: v_r <= 34'((acc_r + mm2_pkg::HALF_DENOM) >>> 23);
      mm2_pkg::ST_DIV: begin
        hi_r <= hi_c;
        lo_r <= lo_c;
      end
      mm2_pkg::ST_DIVR: begin
        sat_r <= hi_r || lo_r;
        if (hi_r) begin
          sum_r <= 17'sd65535;
        end else if (lo_r) begin
          sum_r <= -17'sd65536;
        end else begin
          sum_r <= $signed(q);
        end
      end
      mm2_pkg::ST_E2: ff_r <= prod[23:0];
      mm2_pkg::ST_E3: t1_r <= prod[27:0];
      mm2_pkg::ST_E4: t2_r <= prod[38:0];
      mm2_pkg::ST_E5: begin
        if (sum_r == '0) begin
          factor_r <= 32'h0001_0000;
        end else if (r_val > 42'h0_FFFF_FFFF) begin
          factor_r <= 32'hFFFF_FFFF;
        end else begin
          factor_r <= r_val[31:0];
        end
      end
      default: ;
    endcase
  end

  assign out_tdata = mm2_pkg::out_item_t'{pad: '0, saturated: sat_r, mod_factor: factor_r,
                                          mod_sum: sum_r};

endmodule
